// File: design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register indexes and stage payload types for the
// fixed-point ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Coordinate, edge, cross-product, dot-product and compare widths
  localparam int CoordW = 32;
  localparam int EdgeW  = 33;
  localparam int CrossW = 67;
  localparam int ProdW  = 66;
  localparam int DotW   = 104;
  localparam int CmpW   = 128;
  localparam int EpsW   = 16;

  // Split point of a cross-product operand for the dot multipliers
  localparam int SplitLo = 34;
  // Split point of |A| for the epsilon scaling multiplier
  localparam int ASplit  = 52;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_EPSILON  = 3'd6;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [DotW-1:0]   dot_t;
  typedef logic signed [CmpW-1:0]   cmp_t;

  // Output of the edge / cross-product front end
  typedef struct packed {
    logic            valid;
    edge_t [2:0]     e1;
    edge_t [2:0]     e2;
    edge_t [2:0]     s;
    cross_t [2:0]    h;
    cross_t [2:0]    q;
  } rti_cross_t;

  // Output of the dot-product stages
  typedef struct packed {
    logic valid;
    dot_t a;
    dot_t u;
    dot_t v;
    dot_t t;
  } rti_dot_t;

endpackage

// File: design/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Edges, origin offset and the two cross products h = d x e2, q = s x e1.
// Three register stages: edges, partial products, differences.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [9*rti_pkg::CoordW-1:0] vtx,
  input  rti_pkg::coord_t [2:0]        origin,
  input  rti_pkg::coord_t [2:0]        dir,
  output rti_pkg::rti_cross_t          out
);
  import rti_pkg::*;

  // stage 1: edges and origin offset
  logic        v1_r;
  edge_t [2:0] e1_r, e2_r, s_r;
  edge_t [2:0] e1_nxt, e2_nxt, s_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = edge_t'($signed(vtx[CoordW*(3+i) +: CoordW]))
                - edge_t'($signed(vtx[CoordW*i +: CoordW]));
      e2_nxt[i] = edge_t'($signed(vtx[CoordW*(6+i) +: CoordW]))
                - edge_t'($signed(vtx[CoordW*i +: CoordW]));
      s_nxt[i]  = edge_t'(origin[i]) - edge_t'($signed(vtx[CoordW*i +: CoordW]));
    end
  end

  // stage 2: the twelve cross-product terms
  logic                    v2_r;
  edge_t [2:0]             e1_2_r, e2_2_r, s_2_r;
  logic signed [ProdW-1:0] ph_r [6];
  logic signed [ProdW-1:0] pq_r [6];
  logic signed [ProdW-1:0] ph_nxt [6];
  logic signed [ProdW-1:0] pq_nxt [6];
  edge_t [2:0]             dx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i] = edge_t'(dir[i]);
    end
    ph_nxt[0] = $signed(dx[1]) * $signed(e2_r[2]);
    ph_nxt[1] = $signed(dx[2]) * $signed(e2_r[1]);
    ph_nxt[2] = $signed(dx[2]) * $signed(e2_r[0]);
    ph_nxt[3] = $signed(dx[0]) * $signed(e2_r[2]);
    ph_nxt[4] = $signed(dx[0]) * $signed(e2_r[1]);
    ph_nxt[5] = $signed(dx[1]) * $signed(e2_r[0]);
    pq_nxt[0] = $signed(s_r[1]) * $signed(e1_r[2]);
    pq_nxt[1] = $signed(s_r[2]) * $signed(e1_r[1]);
    pq_nxt[2] = $signed(s_r[2]) * $signed(e1_r[0]);
    pq_nxt[3] = $signed(s_r[0]) * $signed(e1_r[2]);
    pq_nxt[4] = $signed(s_r[0]) * $signed(e1_r[1]);
    pq_nxt[5] = $signed(s_r[1]) * $signed(e1_r[0]);
  end

  // stage 3: cross-product differences
  logic         v3_r;
  edge_t [2:0]  e1_3_r, e2_3_r, s_3_r;
  cross_t [2:0] h_r, q_r;
  cross_t [2:0] h_nxt, q_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_nxt[i] = cross_t'(ph_r[2*i]) - cross_t'(ph_r[2*i+1]);
      q_nxt[i] = cross_t'(pq_r[2*i]) - cross_t'(pq_r[2*i+1]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      s_r    <= s_nxt;
      e1_2_r <= e1_r;
      e2_2_r <= e2_r;
      s_2_r  <= s_r;
      for (int k = 0; k < 6; k++) begin
        ph_r[k] <= ph_nxt[k];
        pq_r[k] <= pq_nxt[k];
      end
      e1_3_r <= e1_2_r;
      e2_3_r <= e2_2_r;
      s_3_r  <= s_2_r;
      h_r    <= h_nxt;
      q_r    <= q_nxt;
    end
  end

  assign out.valid = v3_r;
  assign out.e1    = e1_3_r;
  assign out.e2    = e2_3_r;
  assign out.s     = s_3_r;
  assign out.h     = h_r;
  assign out.q     = q_r;

endmodule

// File: design/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot
// Dot products A = e1.h, U = s.h, V = d.q, T = e2.q. Each wide operand is
// split in two halves; partial products are registered, then summed.
// ----------------------------------------------------------------------------
module rti_dot (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  rti_pkg::rti_cross_t   in,
  input  rti_pkg::coord_t [2:0] dir,
  output rti_pkg::rti_dot_t     out
);
  import rti_pkg::*;

  localparam int LoW = EdgeW + SplitLo + 1;
  localparam int HiW = EdgeW + CrossW - SplitLo;

  // operand pairs: terms 0..2 A, 3..5 U, 6..8 V, 9..11 T
  edge_t  opa [12];
  cross_t opb [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[i]   = in.e1[i];
      opb[i]   = in.h[i];
      opa[3+i] = in.s[i];
      opb[3+i] = in.h[i];
      opa[6+i] = edge_t'(dir[i]);
      opb[6+i] = in.q[i];
      opa[9+i] = in.e2[i];
      opb[9+i] = in.q[i];
    end
  end

  // stage 4: split partial products
  logic                  v4_r;
  logic signed [LoW-1:0] plo_r [12];
  logic signed [HiW-1:0] phi_r [12];
  logic signed [LoW-1:0] plo_nxt [12];
  logic signed [HiW-1:0] phi_nxt [12];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      plo_nxt[k] = $signed(opa[k]) * $signed({1'b0, opb[k][SplitLo-1:0]});
      phi_nxt[k] = $signed(opa[k]) * $signed(opb[k][CrossW-1:SplitLo]);
    end
  end

  // stage 5: recombine and sum three terms per dot product
  logic v5_r;
  dot_t term [12];
  dot_t sum_nxt [4];
  dot_t sum_r [4];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      term[k] = (dot_t'(phi_r[k]) <<< SplitLo) + dot_t'(plo_r[k]);
    end
    for (int j = 0; j < 4; j++) begin
      sum_nxt[j] = term[3*j] + term[3*j+1] + term[3*j+2];
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= in.valid;
      v5_r <= v4_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        plo_r[k] <= plo_nxt[k];
        phi_r[k] <= phi_nxt[k];
      end
      for (int j = 0; j < 4; j++) begin
        sum_r[j] <= sum_nxt[j];
      end
    end
  end

  assign out.valid = v5_r;
  assign out.a     = sum_r[0];
  assign out.u     = sum_r[1];
  assign out.v     = sum_r[2];
  assign out.t     = sum_r[3];

endmodule

// File: design/rti_decide.sv
// ----------------------------------------------------------------------------
// rti_decide
// Sign normalization by the determinant and the division-free hit tests.
// Three register stages: normalize, compare / scale, final distance test.
// ----------------------------------------------------------------------------
module rti_decide #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  rti_pkg::rti_dot_t            in,
  input  logic [rti_pkg::EpsW-1:0]     eps,
  output logic                         hit_valid,
  output logic                         hit
);
  import rti_pkg::*;

  localparam int HiAW = DotW - ASplit;

  // stage 6: flip all four by the sign of A
  logic v6_r, azero_r, azero_nxt;
  dot_t a_r, u_r, vv_r, t_r;
  dot_t a_nxt, u_nxt, vv_nxt, t_nxt;

  always_comb begin
    azero_nxt = (in.a == '0);
    if (in.a[DotW-1]) begin
      a_nxt  = -in.a;
      u_nxt  = -in.u;
      vv_nxt = -in.v;
      t_nxt  = -in.t;
    end else begin
      a_nxt  = in.a;
      u_nxt  = in.u;
      vv_nxt = in.v;
      t_nxt  = in.t;
    end
  end

  // stage 7: range tests on A, U, V and split epsilon * |A|
  logic                       v7_r, miss_r, miss_nxt;
  logic        [EpsW+ASplit-1:0] elo_r, elo_nxt;
  logic signed [EpsW+HiAW:0]     ehi_r, ehi_nxt;
  cmp_t                       tsh_r, tsh_nxt;
  cmp_t                       thr, aw, uw, vw;

  always_comb begin
    thr      = cmp_t'(eps) <<< (2 * FRAC_BITS);
    aw       = cmp_t'(a_r);
    uw       = cmp_t'(u_r);
    vw       = cmp_t'(vv_r);
    miss_nxt = azero_r || (aw < thr) || (uw < 0) || (aw < uw)
            || (vw < 0) || (aw < uw + vw);
    elo_nxt  = eps * a_r[ASplit-1:0];
    ehi_nxt  = $signed({1'b0, eps}) * $signed(a_r[DotW-1:ASplit]);
    tsh_nxt  = cmp_t'(t_r) <<< FRAC_BITS;
  end

  // stage 8: distance test T * 2^F > epsilon * |A|
  logic v8_r, hit_r, hit_nxt;
  cmp_t eps_a;

  always_comb begin
    eps_a   = (cmp_t'(ehi_r) <<< ASplit) + cmp_t'(elo_r);
    hit_nxt = !miss_r && (eps_a < tsh_r);
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v6_r <= in.valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      azero_r <= azero_nxt;
      a_r     <= a_nxt;
      u_r     <= u_nxt;
      vv_r    <= vv_nxt;
      t_r     <= t_nxt;
      miss_r  <= miss_nxt;
      elo_r   <= elo_nxt;
      ehi_r   <= ehi_nxt;
      tsh_r   <= tsh_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign hit_valid = v8_r;
  assign hit       = hit_r;

endmodule

// File: design/ray_triangle_intersection_test.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersection_test
// Fixed-point Moller-Trumbore test of one configured ray against a stream
// of triangles, one hit flag per triangle.
//
//   channel | direction | payload
//   --------+-----------+-----------------------------------------------
//   in_     | slave     | tdata: v0 x,y,z  v1 x,y,z  v2 x,y,z (Q16.16)
//   out_    | master    | tdata: hit (bit 0), zero filled to a byte
//   cfg_    | write     | origin x,y,z, direction x,y,z, epsilon
//
// One triangle per cycle while the skid register is empty. The pipeline
// has 8 stages plus the output register: edges, cross products (2), split
// dot products (2), sign normalize, compare, distance test. Reset clears
// valid bits and sets epsilon to 1. A stalled output parks one result in a
// skid register, and the pipeline freezes only while that register is full.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_test #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // hit, then zero fill
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import rti_pkg::*;

  // configuration registers
  coord_t [2:0]    origin_r, dir_r;
  logic [EpsW-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      dir_r    <= '0;
      eps_r    <= EpsW'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORIGIN_X: origin_r[0] <= cfg_wdata;
        REG_ORIGIN_Y: origin_r[1] <= cfg_wdata;
        REG_ORIGIN_Z: origin_r[2] <= cfg_wdata;
        REG_DIR_X:    dir_r[0]    <= cfg_wdata;
        REG_DIR_Y:    dir_r[1]    <= cfg_wdata;
        REG_DIR_Z:    dir_r[2]    <= cfg_wdata;
        REG_EPSILON:  eps_r       <= cfg_wdata[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid register is empty
  logic        skid_v_r, skid_hit_r;
  logic        out_v_r, out_hit_r;
  logic        en;
  rti_cross_t  cross_s;
  rti_dot_t    dot_s;
  logic        res_v, res_hit;

  assign en        = !skid_v_r;
  assign in_tready = en;

  rti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .vtx      (in_tdata),
    .origin   (origin_r),
    .dir      (dir_r),
    .out      (cross_s)
  );

  rti_dot u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in    (cross_s),
    .dir   (dir_r),
    .out   (dot_s)
  );

  rti_decide #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in        (dot_s),
    .eps       (eps_r),
    .hit_valid (res_v),
    .hit       (res_hit)
  );

  // output register with skid: park a result when the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_tready) begin
      skid_v_r <= res_v;
    end else begin
      out_v_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_hit_r <= skid_hit_r;
      end
    end else if (out_v_r && !out_tready) begin
      skid_hit_r <= res_hit;
    end else begin
      out_hit_r <= res_hit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_hit_r};

  // a parked result always sits behind a shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while the output is empty");

  // a parked result moves forward on the next transfer
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_tready |=> out_v_r && !skid_v_r)
    else $error("skid did not drain into the output register");

  // a pipeline result never lands in a full skid
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r && $stable(skid_hit_r))
    else $error("skid register overwritten while full");

  // the skid fills only when a result arrives while the output is stalled
  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && res_v))
    else $error("skid filled without a stalled result");

endmodule
